### hw/rtl/slcp_pkg.sv
`default_nettype none

package slcp_pkg;

   localparam int LINE_BYTES  = 64;
   localparam int STORE_DEPTH = LINE_BYTES - 1;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(LINE_BYTES);

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic REG_IDLE_TIMEOUT = 1'b0;
   localparam logic [7:0] IDLE_TIMEOUT_RESET = 8'd6;
   localparam logic [7:0] IDLE_MAX = 8'hFF;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [3:0][7:0] WORD_PING = "PING";
   localparam logic [2:0][7:0] WORD_LED  = "LED";
   localparam logic [2:0][7:0] WORD_OFF  = "OFF";

   localparam logic [23:0] RGB_BLACK = 24'h000000;
   localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;

   typedef enum logic [2:0] {
      REPLY_PONG      = 3'd0,
      REPLY_OK        = 3'd1,
      REPLY_BAD_COLOR = 3'd2,
      REPLY_UNKNOWN   = 3'd3,
      REPLY_TOO_LONG  = 3'd4,
      REPLY_LINK_LOST = 3'd5
   } reply_type;

   typedef enum logic [1:0] {
      PARSE_IDLE,
      PARSE_SCAN,
      PARSE_MATCH
   } parse_state_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic        has_result;
      reply_type   reply;
      logic        led_write;
      logic [23:0] rgb;
   } parse_status_type;

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] u;
      u = c;
      if (c inside {[8'h61:8'h7A]}) begin
         u = c - 8'd32;
      end
      return u;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      logic [7:0] u;
      u = to_upper(c);
      return (c inside {[8'h30:8'h39]}) || (u inside {[8'h41:8'h46]});
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] u;
      logic [7:0] v;
      u = to_upper(c);
      if (c inside {[8'h30:8'h39]}) begin
         v = c - 8'h30;
      end else begin
         v = u - 8'h37;
      end
      return v[3:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/slcp_channels.sv
`default_nettype none

interface slcp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, action, rx_byte, input ready);
   modport sink (input valid, action, rx_byte, output ready);
endinterface

interface slcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] reply;
   logic       led_write;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, reply, led_write, red, green, blue, input ready);
   modport sink (input valid, reply, led_write, red, green, blue, output ready);
endinterface

`default_nettype wire

### hw/rtl/slcp_ram.sv
`default_nettype none

module slcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 63
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/slcp_line_parser.sv
`default_nettype none

module slcp_line_parser (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [slcp_pkg::CNT_W-1:0] fill,
   output logic      [slcp_pkg::ADDR_W-1:0] rd_addr,
   input  wire logic [7:0]                 rd_data,
   output slcp_pkg::parse_status_type      status
);

   import slcp_pkg::*;

   parse_state_type state_ff, state_in;

   logic [CNT_W-1:0] iss_ff, iss_in;
   logic [CNT_W-1:0] lim_ff, lim_in;
   logic             dv_ff, dv_in;
   logic [CNT_W-1:0] didx_ff, didx_in;
   logic             nul_ff, nul_in;
   logic             found_ff, found_in;
   logic [CNT_W-1:0] first_ff, first_in;
   logic [CNT_W-1:0] last_ff, last_in;
   logic             ping_ff, ping_in;
   logic             led_ff, led_in;
   logic             blank3_ff, blank3_in;
   logic             sp4_ff, sp4_in;
   logic             pfound_ff, pfound_in;
   logic [2:0]       ridx_ff, ridx_in;
   logic             off_ff, off_in;
   logic             hex_ff, hex_in;
   logic [23:0]      rgb_ff, rgb_in;

   logic             issue;
   logic             scan_end;
   logic [CNT_W-1:0] k;
   logic [CNT_W-1:0] len;
   logic [7:0]       u;

   assign issue    = (state_ff != PARSE_IDLE) && (iss_ff < lim_ff);
   assign scan_end = (iss_ff >= lim_ff) && !dv_ff;
   assign k        = didx_ff - first_ff;
   assign len      = lim_ff - first_ff;
   assign u        = to_upper(rd_data);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PARSE_IDLE: begin
            if (start) begin
               state_in = PARSE_SCAN;
            end
         end
         PARSE_SCAN: begin
            if (scan_end) begin
               state_in = found_ff ? PARSE_MATCH : PARSE_IDLE;
            end
         end
         PARSE_MATCH: begin
            if (scan_end) begin
               state_in = PARSE_IDLE;
            end
         end
         default: state_in = PARSE_IDLE;
      endcase
   end

   always_comb begin
      iss_in    = iss_ff;
      lim_in    = lim_ff;
      dv_in     = 1'b0;
      didx_in   = didx_ff;
      nul_in    = nul_ff;
      found_in  = found_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      ping_in   = ping_ff;
      led_in    = led_ff;
      blank3_in = blank3_ff;
      sp4_in    = sp4_ff;
      pfound_in = pfound_ff;
      ridx_in   = ridx_ff;
      off_in    = off_ff;
      hex_in    = hex_ff;
      rgb_in    = rgb_ff;

      if (issue) begin
         iss_in  = iss_ff + 1'b1;
         dv_in   = 1'b1;
         didx_in = iss_ff;
      end

      case (state_ff)
         PARSE_IDLE: begin
            if (start) begin
               iss_in   = '0;
               lim_in   = fill;
               nul_in   = 1'b0;
               found_in = 1'b0;
               first_in = '0;
               last_in  = '0;
            end
         end
         PARSE_SCAN: begin
            if (dv_ff && !nul_ff) begin
               if (rd_data == CHAR_NUL) begin
                  nul_in = 1'b1;
               end else if (!is_blank(rd_data)) begin
                  if (!found_ff) begin
                     found_in = 1'b1;
                     first_in = didx_ff;
                  end
                  last_in = didx_ff + 1'b1;
               end
            end
            if (scan_end) begin
               iss_in    = first_ff;
               lim_in    = last_ff;
               ping_in   = 1'b1;
               led_in    = 1'b1;
               blank3_in = 1'b0;
               sp4_in    = 1'b0;
               pfound_in = 1'b0;
               ridx_in   = '0;
               off_in    = 1'b1;
               hex_in    = 1'b1;
               rgb_in    = '0;
            end
         end
         PARSE_MATCH: begin
            if (dv_ff) begin
               if (k < CNT_W'(4)) begin
                  ping_in = ping_ff && (u == WORD_PING[2'd3 - k[1:0]]);
               end
               if (k < CNT_W'(3)) begin
                  led_in = led_ff && (u == WORD_LED[2'd2 - k[1:0]]);
               end
               if (k == CNT_W'(3)) begin
                  blank3_in = is_blank(rd_data);
               end
               if (k == CNT_W'(4)) begin
                  sp4_in = (rd_data == CHAR_SPACE);
               end
               if ((k >= CNT_W'(3)) && (pfound_ff || !is_blank(rd_data))) begin
                  pfound_in = 1'b1;
                  if (ridx_ff < 3'd3) begin
                     off_in = off_ff && (u == WORD_OFF[2'd2 - ridx_ff[1:0]]);
                  end
                  if (ridx_ff < 3'd6) begin
                     hex_in = hex_ff && is_hex(rd_data);
                     rgb_in = {rgb_ff[19:0], hex_val(rd_data)};
                  end
                  if (ridx_ff != 3'd7) begin
                     ridx_in = ridx_ff + 3'd1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      status            = '0;
      status.busy       = (state_ff != PARSE_IDLE);
      status.reply      = REPLY_UNKNOWN;
      status.rgb        = RGB_BLACK;
      rd_addr           = iss_ff[ADDR_W-1:0];
      case (state_ff)
         PARSE_SCAN: begin
            status.done = scan_end && !found_ff;
         end
         PARSE_MATCH: begin
            status.done       = scan_end;
            status.has_result = 1'b1;
            if (ping_ff && (len >= CNT_W'(4)) && ((len == CNT_W'(4)) || sp4_ff)) begin
               status.reply = REPLY_PONG;
            end else if (led_ff && (len > CNT_W'(3)) && blank3_ff) begin
               if ((ridx_ff == 3'd3) && off_ff) begin
                  status.reply     = REPLY_OK;
                  status.led_write = 1'b1;
               end else if ((ridx_ff == 3'd6) && hex_ff) begin
                  status.reply     = REPLY_OK;
                  status.led_write = 1'b1;
                  status.rgb       = rgb_ff;
               end else begin
                  status.reply = REPLY_BAD_COLOR;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PARSE_IDLE;
         iss_ff   <= '0;
         lim_ff   <= '0;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         iss_ff   <= iss_in;
         lim_ff   <= lim_in;
         dv_ff    <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      didx_ff   <= didx_in;
      nul_ff    <= nul_in;
      found_ff  <= found_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      ping_ff   <= ping_in;
      led_ff    <= led_in;
      blank3_ff <= blank3_in;
      sp4_ff    <= sp4_in;
      pfound_ff <= pfound_in;
      ridx_ff   <= ridx_in;
      off_ff    <= off_in;
      hex_ff    <= hex_in;
      rgb_ff    <= rgb_in;
   end

endmodule

`default_nettype wire

### hw/rtl/serial_led_command_parser_unit.sv
// channel   dir  handshake     contents
// req_ch    in   valid/ready   action, rx_byte
// rsp_ch    out  valid/ready   reply, led_write, red, green, blue
// csr       in   apb write     idle_timeout_periods at byte address 0
//
// a tick or a stored byte leaves ready high unless it leaves a result
// a line end reads the line store through its single read port, once to find
// the trimmed line and, when that is not empty, once more to match it
// reset is synchronous; line store needs no clearing, only the fill count
// one result waits in a holding register while the output register is stalled,
// and new transactions are held off until it moves
`default_nettype none

module serial_led_command_parser_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   slcp_req_if.sink                                 req_ch,
   slcp_rsp_if.source                               rsp_ch,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [slcp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [slcp_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [slcp_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                     pready
);

   import slcp_pkg::*;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [7:0]       idle_ff, idle_in;
   logic             lost_ff, lost_in;
   logic [7:0]       timeout_ff, timeout_in;

   logic             pend_valid_ff, pend_valid_in;
   reply_type        pend_reply_ff, pend_reply_in;
   logic             pend_led_ff, pend_led_in;
   logic [23:0]      pend_rgb_ff, pend_rgb_in;

   logic             rsp_valid_ff, rsp_valid_in;
   reply_type        rsp_reply_ff, rsp_reply_in;
   logic             rsp_led_ff, rsp_led_in;
   logic [23:0]      rsp_rgb_ff, rsp_rgb_in;

   logic             accept;
   logic             is_eol;
   logic             parse_start;
   logic             wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   logic             pend_move;
   parse_status_type pstat;

   assign accept      = req_ch.valid && req_ch.ready;
   assign is_eol      = (req_ch.rx_byte == CHAR_LF) || (req_ch.rx_byte == CHAR_CR);
   assign parse_start = accept && !req_ch.action && is_eol && (fill_ff != '0);
   assign wr_en       = accept && !req_ch.action && !is_eol
                        && (fill_ff < CNT_W'(STORE_DEPTH));
   assign pend_move   = pend_valid_ff && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready = !pstat.busy && !pend_valid_ff;

   slcp_ram #(
      .WIDTH(8),
      .DEPTH(STORE_DEPTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(fill_ff[ADDR_W-1:0]),
      .wr_data(req_ch.rx_byte),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   slcp_line_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .start  (parse_start),
      .fill   (fill_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .status (pstat)
   );

   always_comb begin
      fill_in       = fill_ff;
      idle_in       = idle_ff;
      lost_in       = lost_ff;
      pend_valid_in = pend_valid_ff;
      pend_reply_in = pend_reply_ff;
      pend_led_in   = pend_led_ff;
      pend_rgb_in   = pend_rgb_ff;

      if (pend_move) begin
         pend_valid_in = 1'b0;
      end

      if (accept) begin
         if (req_ch.action) begin
            if (idle_ff != IDLE_MAX) begin
               idle_in = idle_ff + 8'd1;
            end
            if ((idle_ff >= timeout_ff) && !lost_ff) begin
               lost_in       = 1'b1;
               pend_valid_in = 1'b1;
               pend_reply_in = REPLY_LINK_LOST;
               pend_led_in   = 1'b1;
               pend_rgb_in   = RGB_WHITE;
            end
         end else begin
            idle_in = '0;
            lost_in = 1'b0;
            if (is_eol) begin
               fill_in = '0;
            end else if (wr_en) begin
               fill_in = fill_ff + 1'b1;
            end else begin
               fill_in       = '0;
               pend_valid_in = 1'b1;
               pend_reply_in = REPLY_TOO_LONG;
               pend_led_in   = 1'b0;
               pend_rgb_in   = RGB_BLACK;
            end
         end
      end

      if (pstat.done && pstat.has_result) begin
         pend_valid_in = 1'b1;
         pend_reply_in = pstat.reply;
         pend_led_in   = pstat.led_write;
         pend_rgb_in   = pstat.rgb;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_reply_in = rsp_reply_ff;
      rsp_led_in   = rsp_led_ff;
      rsp_rgb_in   = rsp_rgb_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_move) begin
         rsp_valid_in = 1'b1;
         rsp_reply_in = pend_reply_ff;
         rsp_led_in   = pend_led_ff;
         rsp_rgb_in   = pend_rgb_ff;
      end
   end

   always_comb begin
      timeout_in = timeout_ff;
      if (psel && penable && pwrite && (paddr[2] == REG_IDLE_TIMEOUT)) begin
         timeout_in = pwdata[7:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_IDLE_TIMEOUT) ? CSR_DATA_W'(timeout_ff) : '0;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.reply     = rsp_reply_ff;
   assign rsp_ch.led_write = rsp_led_ff;
   assign rsp_ch.red       = rsp_rgb_ff[23:16];
   assign rsp_ch.green     = rsp_rgb_ff[15:8];
   assign rsp_ch.blue      = rsp_rgb_ff[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         idle_ff       <= '0;
         lost_ff       <= 1'b0;
         timeout_ff    <= IDLE_TIMEOUT_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         idle_ff       <= idle_in;
         lost_ff       <= lost_in;
         timeout_ff    <= timeout_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_reply_ff <= pend_reply_in;
      pend_led_ff   <= pend_led_in;
      pend_rgb_ff   <= pend_rgb_in;
      rsp_reply_ff  <= rsp_reply_in;
      rsp_led_ff    <= rsp_led_in;
      rsp_rgb_ff    <= rsp_rgb_in;
   end

endmodule

`default_nettype wire

### dv/slcp_reply_checker.sv
`default_nettype none

module slcp_reply_checker
   import slcp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   slcp_req_if                        req_mon,
   slcp_rsp_if                        rsp_mon,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   input  wire logic [CSR_DATA_W-1:0] prdata,
   input  wire logic                  pready,
   output int                         fail_count,
   output int                         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      reply_type  reply;
      logic       led_write;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } led_reply_type;

   logic [7:0]    line_copy [STORE_DEPTH];
   int            line_fill;
   int            idle_periods;
   logic          lost_seen;
   logic [7:0]    timeout_periods;
   led_reply_type awaited_replies [$];
   int            mismatches = 0;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
   endfunction

   function automatic logic blank_char(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic int hex_digit(input logic [7:0] c);
      logic [7:0] u;
      u = upcase(c);
      if (c >= 8'h30 && c <= 8'h39) begin
         return int'(c - 8'h30);
      end
      if (u >= 8'h41 && u <= 8'h46) begin
         return int'(u - 8'h37);
      end
      return -1;
   endfunction

   function automatic logic word_found(input int pos, input int stop, input string w);
      int i;
      if (stop - pos < w.len()) begin
         return 1'b0;
      end
      for (i = 0; i < w.len(); i++) begin
         if (upcase(line_copy[pos + i]) != 8'(w[i])) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // decode the finished line, returns 0 when the trimmed line is empty
   function automatic logic decode_line(output led_reply_type res);
      int         stop;
      int         first;
      int         p;
      int         i;
      int         h;
      logic       all_hex;
      logic [23:0] rgb;
      res.reply = REPLY_UNKNOWN;
      res.led_write = 1'b0;
      {res.red, res.green, res.blue} = RGB_BLACK;
      rgb = RGB_BLACK;
      stop = 0;
      first = 0;
      while (stop < line_fill && line_copy[stop] != CHAR_NUL) stop++;
      while (first < stop && blank_char(line_copy[first])) first++;
      while (stop > first && blank_char(line_copy[stop - 1])) stop--;
      if (stop == first) begin
         return 1'b0;
      end
      if (word_found(first, stop, "PING") &&
          (stop - first == 4 || line_copy[first + 4] == CHAR_SPACE)) begin
         res.reply = REPLY_PONG;
         return 1'b1;
      end
      if (word_found(first, stop, "LED") && stop - first > 3 &&
          blank_char(line_copy[first + 3])) begin
         p = first + 3;
         while (p < stop && blank_char(line_copy[p])) p++;
         if (stop - p == 3 && word_found(p, stop, "OFF")) begin
            res.reply = REPLY_OK;
            res.led_write = 1'b1;
            return 1'b1;
         end
         if (stop - p == 6) begin
            all_hex = 1'b1;
            for (i = 0; i < 6; i++) begin
               h = hex_digit(line_copy[p + i]);
               if (h < 0) begin
                  all_hex = 1'b0;
               end
               rgb = {rgb[19:0], h[3:0]};
            end
            if (all_hex) begin
               res.reply = REPLY_OK;
               res.led_write = 1'b1;
               {res.red, res.green, res.blue} = rgb;
               return 1'b1;
            end
         end
         res.reply = REPLY_BAD_COLOR;
         return 1'b1;
      end
      return 1'b1;
   endfunction

   task automatic predict_reply(input logic act, input logic [7:0] b);
      led_reply_type res;
      logic          idle_expired;
      res.reply = REPLY_TOO_LONG;
      res.led_write = 1'b0;
      {res.red, res.green, res.blue} = RGB_BLACK;
      if (act) begin
         idle_expired = idle_periods >= int'(timeout_periods);
         if (idle_periods < int'(IDLE_MAX)) begin
            idle_periods++;
         end
         if (idle_expired && !lost_seen) begin
            lost_seen = 1'b1;
            res.reply = REPLY_LINK_LOST;
            res.led_write = 1'b1;
            {res.red, res.green, res.blue} = RGB_WHITE;
            awaited_replies.push_back(res);
         end
      end else begin
         idle_periods = 0;
         lost_seen = 1'b0;
         if (b == CHAR_LF || b == CHAR_CR) begin
            if (line_fill > 0) begin
               if (decode_line(res)) begin
                  awaited_replies.push_back(res);
               end
               line_fill = 0;
            end
         end else if (line_fill < STORE_DEPTH) begin
            line_copy[line_fill] = b;
            line_fill++;
         end else begin
            line_fill = 0;
            awaited_replies.push_back(res);
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic check_reply();
      led_reply_type got;
      led_reply_type want;
      got.reply = reply_type'(rsp_mon.reply);
      got.led_write = rsp_mon.led_write;
      got.red = rsp_mon.red;
      got.green = rsp_mon.green;
      got.blue = rsp_mon.blue;
      if (awaited_replies.size() == 0) begin
         report_mismatch($sformatf("reply %0d rgb %02h%02h%02h with none expected",
                                   got.reply, got.red, got.green, got.blue));
      end else begin
         want = awaited_replies.pop_front();
         if (got.reply !== want.reply || got.led_write !== want.led_write ||
             got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            report_mismatch($sformatf(
               "reply %0d/%0d led_write %0d/%0d rgb %02h%02h%02h/%02h%02h%02h (got/exp)",
               got.reply, want.reply, got.led_write, want.led_write,
               got.red, got.green, got.blue, want.red, want.green, want.blue));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         line_fill = 0;
         idle_periods = 0;
         lost_seen = 1'b0;
         timeout_periods = IDLE_TIMEOUT_RESET;
         awaited_replies.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_reply();
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_reply(req_mon.action, req_mon.rx_byte);
         end
         if (psel && penable && pready && paddr[CSR_ADDR_W-1:2] == REG_IDLE_TIMEOUT) begin
            if (pwrite) begin
               timeout_periods = pwdata[7:0];
            end else if (prdata[7:0] !== timeout_periods) begin
               report_mismatch($sformatf("timeout register read %0d, expected %0d",
                                         prdata[7:0], timeout_periods));
            end
         end
      end
      pending_count <= awaited_replies.size();
      fail_count <= mismatches;
   end

endmodule

`default_nettype wire

### dv/tb_serial_led_command_parser_unit.sv
`default_nettype none

module tb_serial_led_command_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import slcp_pkg::*;

   localparam int   CYCLE_LIMIT  = 500000;
   localparam int   SETTLE_WAIT  = 200;
   localparam logic REG_SPARE    = 1'b1;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count;
   int                    pending_count;
   int                    cycle_count = 0;
   int                    items_sent = 0;
   int                    req_gap_pct;
   int                    rsp_stall_pct;
   int                    stall_left = 0;
   logic [7:0]            cur_timeout;
   logic [7:0]            line_bytes [$];

   slcp_req_if req_ch();
   slcp_rsp_if rsp_ch();

   serial_led_command_parser_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   slcp_reply_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("serial_led_command_parser_unit test failed");
         $finish;
      end
   end

   // result side back-pressure in bursts of random length
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= $urandom_range(1, 4) - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic send_item(input logic act, input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 99) < req_gap_pct) begin
         gap = $urandom_range(1, 4);
         req_ch.valid <= 1'b0;
         req_ch.action <= 1'($urandom_range(0, 1));
         req_ch.rx_byte <= 8'($urandom_range(0, 255));
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic drive_line();
      foreach (line_bytes[i]) begin
         send_item(1'b0, line_bytes[i]);
      end
      line_bytes.delete();
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_item(1'b1, 8'($urandom_range(0, 255)));
   endtask

   // wait until every predicted reply has arrived, then let the unit settle
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic idx, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timeout(input logic [7:0] v);
      logic [23:0] junk;
      junk = 24'($urandom);
      settle();
      csr_access(1'b1, REG_IDLE_TIMEOUT, {junk, v});
      csr_access(1'b1, REG_SPARE, $urandom);
      csr_access(1'b0, REG_IDLE_TIMEOUT, '0);
      cur_timeout = v;
   endtask

   function automatic logic [7:0] any_case(input logic [7:0] c);
      if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(0, 1)) begin
         return c ^ 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   task automatic add_text(input string s, input logic mix);
      for (int i = 0; i < s.len(); i++) begin
         line_bytes.push_back(mix ? any_case(8'(s[i])) : 8'(s[i]));
      end
   endtask

   task automatic add_blanks(input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) begin
         line_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      end
   endtask

   task automatic add_word(input int max_len);
      repeat ($urandom_range(1, max_len)) begin
         line_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end
   endtask

   task automatic add_hex(input int n);
      string digits;
      digits = "0123456789abcdefABCDEF";
      repeat (n) line_bytes.push_back(8'(digits[$urandom_range(0, 21)]));
   endtask

   task automatic build_line();
      int    n;
      string bad;
      bad = "gG/:@`zZ";
      case ($urandom_range(0, 15))
         0, 1, 2: begin
            add_blanks(0, 2);
            add_text("PING", 1'b1);
            case ($urandom_range(0, 3))
               0: ;
               1: begin
                  line_bytes.push_back(CHAR_SPACE);
                  add_word(6);
               end
               2: begin
                  line_bytes.push_back(CHAR_TAB);
                  add_word(6);
               end
               default: add_word(3);
            endcase
            add_blanks(0, 2);
         end
         3, 4: begin
            add_blanks(0, 2);
            add_text("LED", 1'b1);
            add_blanks(1, 3);
            add_text("OFF", 1'b1);
            if ($urandom_range(0, 3) == 0) begin
               add_word(2);
            end
            add_blanks(0, 2);
         end
         5, 6, 7, 8: begin
            add_blanks(0, 2);
            add_text("LED", 1'b1);
            add_blanks(1, 3);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : 6;
            add_hex(n);
            if (n > 0 && $urandom_range(0, 4) == 0) begin
               line_bytes[line_bytes.size() - 1 - $urandom_range(0, n - 1)] =
                  8'(bad[$urandom_range(0, 7)]);
            end
            add_blanks(0, 2);
         end
         9: begin
            add_text("LED", 1'b1);
            if ($urandom_range(0, 1)) begin
               add_hex(6);
            end
         end
         10, 11: begin
            add_blanks(0, 1);
            repeat ($urandom_range(1, 3)) begin
               add_word(8);
               add_blanks(1, 2);
            end
         end
         12: begin
            repeat ($urandom_range(1, 20)) line_bytes.push_back(8'($urandom_range(0, 255)));
         end
         13: begin
            repeat ($urandom_range(60, 72)) line_bytes.push_back(text_byte());
         end
         14: begin
            case ($urandom_range(0, 2))
               0: add_text("PING", 1'b1);
               1: begin
                  add_text("LED ", 1'b1);
                  add_hex(6);
               end
               default: ;
            endcase
            line_bytes.push_back(CHAR_NUL);
            repeat ($urandom_range(0, 6)) line_bytes.push_back(text_byte());
         end
         default: add_blanks(0, 4);
      endcase
      line_bytes.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
   endtask

   task automatic run_traffic(input int n_items);
      int stop_at;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 5) == 0) begin
            send_ticks($urandom_range(1, (cur_timeout > 20) ? 8 : int'(cur_timeout) + 3));
         end else begin
            build_line();
            drive_line();
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.action <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      cur_timeout = IDLE_TIMEOUT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // pong, black, colour, high byte with zero truncation, empty line, link loss
      add_text("PiNg", 1'b0);
      line_bytes.push_back(CHAR_CR);
      add_text("led OfF", 1'b0);
      line_bytes.push_back(CHAR_LF);
      add_text("Led", 1'b0);
      line_bytes.push_back(CHAR_TAB);
      add_text("fF00a9", 1'b0);
      line_bytes.push_back(CHAR_CR);
      line_bytes.push_back(8'hFF);
      line_bytes.push_back(CHAR_NUL);
      line_bytes.push_back(CHAR_LF);
      line_bytes.push_back(CHAR_CR);
      drive_line();
      send_ticks(int'(IDLE_TIMEOUT_RESET) + 2);

      req_gap_pct = 20;
      rsp_stall_pct = 20;
      run_traffic(200);

      set_timeout(8'd1);
      req_gap_pct = 50;
      rsp_stall_pct = 0;
      run_traffic(120);
      settle();
      req_gap_pct = 0;
      rsp_stall_pct = 50;
      run_traffic(120);

      set_timeout(8'd255);
      req_gap_pct = 30;
      rsp_stall_pct = 30;
      run_traffic(100);
      send_ticks(260);
      run_traffic(100);

      set_timeout(8'd0);
      req_gap_pct = 10;
      rsp_stall_pct = 40;
      run_traffic(200);

      set_timeout(8'($urandom_range(2, 40)));
      req_gap_pct = 40;
      rsp_stall_pct = 10;
      run_traffic(200);

      set_timeout(8'd3);
      req_gap_pct = 20;
      rsp_stall_pct = 20;
      run_traffic(100);
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      run_traffic(100);

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("serial_led_command_parser_unit test passed");
      end else begin
         $display("serial_led_command_parser_unit test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
hw/rtl/slcp_pkg.sv
hw/rtl/slcp_channels.sv
hw/rtl/slcp_ram.sv
hw/rtl/slcp_line_parser.sv
hw/rtl/serial_led_command_parser_unit.sv
dv/slcp_reply_checker.sv
dv/tb_serial_led_command_parser_unit.sv
